/* design/bgca_pkg.sv */
`default_nettype none

package bgca_pkg;

  // Default grid capacity.
  localparam int MaxWidthDef  = 64;
  localparam int MaxHeightDef = 64;

  // Opcodes of an input transaction.
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Configuration register indexes.
  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 16;
  localparam logic [CfgIndexW-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_THRESHOLD   = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_GEN_COUNT   = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_HOOD_MODE   = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_SURVIVE_MIN = 3'd5;
  localparam logic [CfgIndexW-1:0] CFG_BIRTH_MIN   = 3'd6;

  // Neighborhood modes.
  localparam logic [1:0] HOOD_DIAMOND4  = 2'd0;
  localparam logic [1:0] HOOD_SQUARE8   = 2'd1;
  localparam logic [1:0] HOOD_DIAMOND12 = 2'd2;
  localparam logic [1:0] HOOD_SQUARE24  = 2'd3;

  // Result kinds.
  localparam logic KIND_RUN_DONE = 1'b0;
  localparam logic KIND_READ     = 1'b1;

  // The 5x5 window is scanned with two offset counters running 0..4.
  localparam logic [2:0] OFS_CENTER = 3'd2;
  localparam logic [2:0] OFS_LAST   = 3'd4;

  typedef struct packed {
    logic load;
    logic read;
    logic run_start;
    logic scan;
    logic gen_write;
    logic copy_wr;
    logic gen_adv;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rd_pend;
    logic out_blocked;
    logic out_free;
    logic gen_zero;
    logic gen_last;
    logic scan_last;
    logic cell_last;
  } dp_stat_t;

  // True when window offset (dr, dc), each 0..4 with 2 as the center, belongs
  // to the selected neighborhood.
  function automatic logic in_hood(logic [2:0] dr, logic [2:0] dc, logic [1:0] mode);
    logic [1:0] ar;
    logic [1:0] ac;
    logic [2:0] manh;
    logic [1:0] cheb;
    logic       hit;
    ar   = (dr >= OFS_CENTER) ? 2'(dr - OFS_CENTER) : 2'(OFS_CENTER - dr);
    ac   = (dc >= OFS_CENTER) ? 2'(dc - OFS_CENTER) : 2'(OFS_CENTER - dc);
    manh = {1'b0, ar} + {1'b0, ac};
    cheb = (ar > ac) ? ar : ac;
    case (mode)
      HOOD_DIAMOND4:  hit = (manh == 3'd1);
      HOOD_SQUARE8:   hit = (cheb == 2'd1);
      HOOD_DIAMOND12: hit = (manh <= 3'd2);
      default:        hit = 1'b1;
    endcase
    return hit && (manh != 3'd0);
  endfunction

endpackage

`default_nettype wire

/* design/binary_grid_cellular_automaton.sv */
// A load transaction is written in its accept cycle; a read result is registered in the grid
// RAM, then in the result register. Throughput: one load per cycle while the block is idle and
// the output is not blocked; a read holds the input until its result is registered. A run is
// 25 window reads, drain and write per cell, then a copy back per cell, for each generation.
// Reset (rst_n, synchronous, active low) clears the controller, the result register and
// restores the configuration registers; the grid RAMs hold no reset value.
`default_nettype none

module binary_grid_cellular_automaton #(
  parameter int MAX_WIDTH  = bgca_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = bgca_pkg::MaxHeightDef
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [bgca_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [bgca_pkg::CfgDataW-1:0]  cfg_wdata,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic [1:0]                     in_op,
  input  wire logic [5:0]                     in_row,
  input  wire logic [5:0]                     in_col,
  input  wire logic [15:0]                    in_sample,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic                           out_kind,
  output      logic                           out_is_path
);

  // The controller sequences a run: for each cell it scans the 5x5 window one
  // neighbor per cycle through the current-grid RAM, writes the new state to
  // the second grid, and after a full generation copies the used region back.
  // Cells outside the used region are left as they are, so a later size change
  // still finds them in place.
  bgca_pkg::ctrl_cmd_t cmd;
  bgca_pkg::dp_stat_t  stat;

  bgca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // The datapath owns the configuration registers, the sweep counters, both
  // grid memories and the result register that holds a transaction while the
  // output side stalls.
  bgca_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_row      (in_row),
    .in_col      (in_col),
    .in_sample   (in_sample),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_kind    (out_kind),
    .out_is_path (out_is_path)
  );

`ifndef ASSERT_OFF
  // A run transaction keeps the block busy on the following cycle.
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == bgca_pkg::OP_RUN) |=> in_stall)
    else $error("run accepted but block not busy");

  // A pending read blocks the input until its result is registered.
  a_read_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == bgca_pkg::OP_READ) |=> in_stall && !out_valid)
    else $error("read result timing broken");

  // A run-finished result never reports a path cell.
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == bgca_pkg::KIND_RUN_DONE) |-> !out_is_path)
    else $error("run finished with path bit set");
`endif

endmodule

`default_nettype wire

/* design/bgca_ram.sv */
`default_nettype none

module bgca_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/bgca_ctrl.sv */
`default_nettype none

module bgca_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [1:0]          in_op,
  input  wire bgca_pkg::dp_stat_t  stat,
  output      logic                in_stall,
  output      bgca_pkg::ctrl_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_DRAIN   = 3'd2;
  localparam logic [2:0] ST_WRITE   = 3'd3;
  localparam logic [2:0] ST_COPY_RD = 3'd4;
  localparam logic [2:0] ST_COPY_WR = 3'd5;
  localparam logic [2:0] ST_FINISH  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE) || stat.rd_pend || stat.out_blocked;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load      = accept && (in_op == bgca_pkg::OP_LOAD);
        cmd.read      = accept && (in_op == bgca_pkg::OP_READ);
        cmd.run_start = accept && (in_op == bgca_pkg::OP_RUN);
        if (cmd.run_start) begin
          state_nxt = stat.gen_zero ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.gen_write = 1'b1;
        state_nxt     = stat.cell_last ? ST_COPY_RD : ST_SCAN;
      end
      ST_COPY_RD: begin
        state_nxt = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        cmd.copy_wr = 1'b1;
        if (stat.cell_last) begin
          cmd.gen_adv = 1'b1;
          state_nxt   = stat.gen_last ? ST_FINISH : ST_SCAN;
        end else begin
          state_nxt = ST_COPY_RD;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/bgca_dp.sv */
`default_nettype none

module bgca_dp #(
  parameter int MAX_WIDTH  = bgca_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = bgca_pkg::MaxHeightDef
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [bgca_pkg::CfgIndexW-1:0]     cfg_index,
  input  wire logic [bgca_pkg::CfgDataW-1:0]      cfg_wdata,
  input  wire logic [5:0]                         in_row,
  input  wire logic [5:0]                         in_col,
  input  wire logic [15:0]                        in_sample,
  input  wire logic                               out_stall,
  input  wire bgca_pkg::ctrl_cmd_t                cmd,
  output      bgca_pkg::dp_stat_t                 stat,
  output      logic                               out_valid,
  output      logic                               out_kind,
  output      logic                               out_is_path
);

  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int EW0 = (HW > WW) ? HW : WW;
  localparam int EW  = (EW0 > 7) ? EW0 : 7;
  localparam int AW  = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam logic [EW-1:0] MaxW = EW'(MAX_WIDTH);
  localparam logic [EW-1:0] MaxH = EW'(MAX_HEIGHT);
  localparam logic signed [EW+1:0] OfsBias = (EW+2)'(2);

  // Configuration registers.
  logic [6:0]  grid_width_r;
  logic [6:0]  grid_height_r;
  logic [15:0] threshold_r;
  logic [7:0]  gen_count_r;
  logic [1:0]  hood_mode_r;
  logic [4:0]  survive_min_r;
  logic [4:0]  birth_min_r;

  // Sweep state.
  logic [RW-1:0] r_r;
  logic [CW-1:0] c_r;
  logic [2:0]    dr_r;
  logic [2:0]    dc_r;
  logic [7:0]    gen_r;
  logic [4:0]    cnt_r;
  logic          self_r;
  logic          cnt_pend_r;
  logic          self_pend_r;
  logic          rd_pend_r;
  logic          rd_in_r;
  logic          out_valid_r;
  logic          out_kind_r;
  logic          out_path_r;

  logic [EW-1:0] gw_ext;
  logic [EW-1:0] gh_ext;
  logic [EW-1:0] w_eff;
  logic [EW-1:0] h_eff;
  logic          row_last;
  logic          col_last;
  logic          in_inside;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] cell_addr;
  logic signed [EW+1:0] nr_s;
  logic signed [EW+1:0] nc_s;
  logic          nb_inside;
  logic [AW-1:0] nb_addr;
  logic          nb_count;

  logic          cur_we;
  logic [AW-1:0] cur_waddr;
  logic          cur_wdata;
  logic [AW-1:0] cur_raddr;
  logic          cur_rdata;
  logic          nxt_wdata;
  logic          nxt_rdata;

  // Effective grid size, clamped to 1..MAX.
  assign gw_ext = EW'(grid_width_r);
  assign gh_ext = EW'(grid_height_r);
  assign w_eff  = (gw_ext == '0) ? EW'(1) : ((gw_ext > MaxW) ? MaxW : gw_ext);
  assign h_eff  = (gh_ext == '0) ? EW'(1) : ((gh_ext > MaxH) ? MaxH : gh_ext);

  assign col_last = (EW'(c_r) == (w_eff - EW'(1)));
  assign row_last = (EW'(r_r) == (h_eff - EW'(1)));

  assign in_inside = (EW'(in_row) < h_eff) && (EW'(in_col) < w_eff);
  assign in_addr   = {RW'(in_row), CW'(in_col)};
  assign cell_addr = {r_r, c_r};

  // Neighbor position for the current window offset.
  assign nr_s = $signed({2'b00, EW'(r_r)}) + $signed((EW+2)'(dr_r)) - OfsBias;
  assign nc_s = $signed({2'b00, EW'(c_r)}) + $signed((EW+2)'(dc_r)) - OfsBias;
  assign nb_inside = !nr_s[EW+1] && !nc_s[EW+1] &&
                     (nr_s[EW:0] < {1'b0, h_eff}) && (nc_s[EW:0] < {1'b0, w_eff});
  assign nb_addr  = {nr_s[RW-1:0], nc_s[CW-1:0]};
  assign nb_count = nb_inside && bgca_pkg::in_hood(dr_r, dc_r, hood_mode_r);

  assign nxt_wdata = self_r ? (cnt_r >= survive_min_r) : (cnt_r >= birth_min_r);

  assign cur_we    = (cmd.load && in_inside) || cmd.copy_wr;
  assign cur_waddr = cmd.copy_wr ? cell_addr : in_addr;
  assign cur_wdata = cmd.copy_wr ? nxt_rdata : (in_sample > threshold_r);
  assign cur_raddr = cmd.scan ? nb_addr : in_addr;

  bgca_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_cur_ram (
    .clk     (clk),
    .we      (cur_we),
    .waddr   (cur_waddr),
    .wdata   (cur_wdata),
    .raddr   (cur_raddr),
    .rdata_r (cur_rdata)
  );

  bgca_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_nxt_ram (
    .clk     (clk),
    .we      (cmd.gen_write),
    .waddr   (cell_addr),
    .wdata   (nxt_wdata),
    .raddr   (cell_addr),
    .rdata_r (nxt_rdata)
  );

  assign stat.rd_pend     = rd_pend_r;
  assign stat.out_blocked = out_valid_r && out_stall;
  assign stat.out_free    = !out_valid_r || !out_stall;
  assign stat.gen_zero    = (gen_count_r == '0);
  assign stat.gen_last    = (({1'b0, gen_r} + 9'd1) == {1'b0, gen_count_r});
  assign stat.scan_last   = (dr_r == bgca_pkg::OFS_LAST) && (dc_r == bgca_pkg::OFS_LAST);
  assign stat.cell_last   = row_last && col_last;

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_is_path = out_path_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= 7'd64;
      grid_height_r <= 7'd64;
      threshold_r   <= 16'd32768;
      gen_count_r   <= 8'd4;
      hood_mode_r   <= bgca_pkg::HOOD_SQUARE8;
      survive_min_r <= 5'd4;
      birth_min_r   <= 5'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bgca_pkg::CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata[6:0];
        bgca_pkg::CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata[6:0];
        bgca_pkg::CFG_THRESHOLD:   threshold_r   <= cfg_wdata;
        bgca_pkg::CFG_GEN_COUNT:   gen_count_r   <= cfg_wdata[7:0];
        bgca_pkg::CFG_HOOD_MODE:   hood_mode_r   <= cfg_wdata[1:0];
        bgca_pkg::CFG_SURVIVE_MIN: survive_min_r <= cfg_wdata[4:0];
        bgca_pkg::CFG_BIRTH_MIN:   birth_min_r   <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Sweep counters and neighbor accumulation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r         <= '0;
      c_r         <= '0;
      dr_r        <= '0;
      dc_r        <= '0;
      gen_r       <= '0;
      cnt_r       <= '0;
      self_r      <= 1'b0;
      cnt_pend_r  <= 1'b0;
      self_pend_r <= 1'b0;
    end else begin
      cnt_pend_r  <= cmd.scan && nb_count;
      self_pend_r <= cmd.scan && (dr_r == bgca_pkg::OFS_CENTER) &&
                     (dc_r == bgca_pkg::OFS_CENTER);
      if (self_pend_r) begin
        self_r <= cur_rdata;
      end
      if (cmd.run_start || cmd.gen_write) begin
        cnt_r <= '0;
      end else if (cnt_pend_r) begin
        cnt_r <= cnt_r + 5'(cur_rdata);
      end
      if (cmd.run_start) begin
        r_r   <= '0;
        c_r   <= '0;
        dr_r  <= '0;
        dc_r  <= '0;
        gen_r <= '0;
      end
      if (cmd.scan) begin
        if (dc_r == bgca_pkg::OFS_LAST) begin
          dc_r <= '0;
          dr_r <= (dr_r == bgca_pkg::OFS_LAST) ? 3'd0 : dr_r + 3'd1;
        end else begin
          dc_r <= dc_r + 3'd1;
        end
      end
      if (cmd.gen_write || cmd.copy_wr) begin
        if (col_last) begin
          c_r <= '0;
          r_r <= row_last ? '0 : r_r + RW'(1);
        end else begin
          c_r <= c_r + CW'(1);
        end
      end
      if (cmd.gen_adv) begin
        gen_r <= gen_r + 8'd1;
      end
    end
  end

  // Read pipeline and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.read;
      if (rd_pend_r || cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_in_r <= in_inside;
    end
    if (rd_pend_r) begin
      out_kind_r <= bgca_pkg::KIND_READ;
      out_path_r <= rd_in_r && cur_rdata;
    end else if (cmd.finish) begin
      out_kind_r <= bgca_pkg::KIND_RUN_DONE;
      out_path_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* dv/tb.sv */
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode 3 has no meaning; the block must drop it without a result.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int GridCells = bgca_pkg::MaxWidthDef * bgca_pkg::MaxHeightDef;
  // Cycles in which no transaction moves on either channel before the run is declared hung.
  // The slowest run here is a 1x1 grid with 255 generations.
  localparam int WatchdogLimit = 40000;
  localparam int LongHoldCycles = 300;

  typedef struct {
    logic [1:0]  op;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [15:0] sample;
  } cmd_t;

  typedef struct {
    logic kind;
    logic is_path;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [bgca_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [bgca_pkg::CfgDataW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = bgca_pkg::OP_LOAD;
  logic [5:0] in_row = '0;
  logic [5:0] in_col = '0;
  logic [15:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_kind;
  logic out_is_path;

  binary_grid_cellular_automaton u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_row(in_row),
    .in_col(in_col), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_is_path(out_is_path)
  );

  // Shadow copy of the configuration registers, masked to their widths.
  logic [6:0]  grid_w_reg   = 7'd64;
  logic [6:0]  grid_h_reg   = 7'd64;
  logic [15:0] thresh_reg   = 16'd32768;
  logic [7:0]  gens_reg     = 8'd4;
  logic [1:0]  hood_reg     = bgca_pkg::HOOD_SQUARE8;
  logic [4:0]  survive_reg  = 5'd4;
  logic [4:0]  birth_reg    = 5'd5;

  // Predicted grid contents, and which cells the stimulus has loaded so far.
  bit cave_bits[GridCells];
  bit loaded_map[GridCells];

  cmd_t    cmd_queue[$];
  answer_t answer_queue[$];
  int      mismatches = 0;
  int      results_seen = 0;
  int      idle_cycles = 0;
  bit      calm = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int clamp_dim(logic [6:0] v);
    if (v == 0) return 1;
    if (v > 7'd64) return 64;
    return int'(v);
  endfunction

  function automatic bit hood_member(int dr, int dc, logic [1:0] mode);
    int ar, ac, manh, cheb;
    ar = dr < 0 ? -dr : dr;
    ac = dc < 0 ? -dc : dc;
    manh = ar + ac;
    cheb = ar > ac ? ar : ac;
    if (manh == 0) return 1'b0;
    case (mode)
      bgca_pkg::HOOD_DIAMOND4:  return manh == 1;
      bgca_pkg::HOOD_SQUARE8:   return cheb == 1;
      bgca_pkg::HOOD_DIAMOND12: return manh <= 2;
      default:                  return 1'b1;
    endcase
  endfunction

  // One synchronous birth/survival step over the grid in use.
  task automatic step_generation(int w, int h);
    bit nxt[GridCells];
    int cnt, nr, nc;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        cnt = 0;
        for (int dr = -2; dr <= 2; dr++) begin
          for (int dc = -2; dc <= 2; dc++) begin
            nr = r + dr;
            nc = c + dc;
            if (hood_member(dr, dc, hood_reg) && nr >= 0 && nr < h && nc >= 0 && nc < w)
              cnt += cave_bits[nr * bgca_pkg::MaxWidthDef + nc];
          end
        end
        if (cave_bits[r * bgca_pkg::MaxWidthDef + c])
          nxt[r * bgca_pkg::MaxWidthDef + c] = (cnt >= survive_reg);
        else nxt[r * bgca_pkg::MaxWidthDef + c] = (cnt >= birth_reg);
      end
    end
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        cave_bits[r * bgca_pkg::MaxWidthDef + c] = nxt[r * bgca_pkg::MaxWidthDef + c];
  endtask

  // Updates the predicted grid for one accepted transaction and queues its answer.
  task automatic predict_cave(cmd_t t);
    int w, h;
    bit in_grid;
    answer_t a;
    w = clamp_dim(grid_w_reg);
    h = clamp_dim(grid_h_reg);
    in_grid = (int'(t.row) < h) && (int'(t.col) < w);
    case (t.op)
      bgca_pkg::OP_LOAD: begin
        if (in_grid)
          cave_bits[t.row * bgca_pkg::MaxWidthDef + t.col] = (t.sample > thresh_reg);
      end
      bgca_pkg::OP_RUN: begin
        for (int g = 0; g < int'(gens_reg); g++) step_generation(w, h);
        a.kind = bgca_pkg::KIND_RUN_DONE;
        a.is_path = 1'b0;
        answer_queue.push_back(a);
      end
      bgca_pkg::OP_READ: begin
        a.kind = bgca_pkg::KIND_READ;
        a.is_path = in_grid ? cave_bits[t.row * bgca_pkg::MaxWidthDef + t.col] : 1'b0;
        answer_queue.push_back(a);
      end
      default: ;
    endcase
  endtask

  // Sender: feeds the block from cmd_queue, with random gaps.
  int gap_left = 0;
  always @(posedge clk) begin
    logic nv;
    cmd_t t;
    nv = in_valid;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        t.op = in_op;
        t.row = in_row;
        t.col = in_col;
        t.sample = in_sample;
        predict_cave(t);
      end
      if (!(in_valid && in_stall)) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (cmd_queue.size() > 0) begin
          if (!calm && $urandom_range(0, 9) == 0) begin
            gap_left <= $urandom_range(0, 6);
          end else begin
            t = cmd_queue.pop_front();
            in_op <= t.op;
            in_row <= t.row;
            in_col <= t.col;
            in_sample <= t.sample;
            nv = 1'b1;
          end
        end
      end
    end
    in_valid <= nv;
  end

  // Receiver: random stall bursts, plus one long hold-off after the 40th result
  // so the block backs up and stalls its input side.
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;
  always @(posedge clk) begin
    logic ns;
    ns = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (answer_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d is_path %0d", out_kind, out_is_path);
        end else begin
          answer_t a;
          a = answer_queue.pop_front();
          if (a.kind !== out_kind || a.is_path !== out_is_path) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected kind %0d is_path %0d, got kind %0d is_path %0d",
                       a.kind, a.is_path, out_kind, out_is_path);
          end
        end
      end
      if (!long_hold_done && results_seen == 40) begin
        long_hold_done <= 1'b1;
        hold_left <= LongHoldCycles;
        ns = 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        ns = 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        hold_left <= $urandom_range(0, 6);
        ns = 1'b1;
      end
    end
    out_stall <= ns;
  end

  // Watchdog on cycles in which no transaction moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d results outstanding", answer_queue.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [bgca_pkg::CfgIndexW-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bgca_pkg::CFG_GRID_WIDTH:  grid_w_reg = val[6:0];
      bgca_pkg::CFG_GRID_HEIGHT: grid_h_reg = val[6:0];
      bgca_pkg::CFG_THRESHOLD:   thresh_reg = val[15:0];
      bgca_pkg::CFG_GEN_COUNT:   gens_reg = val[7:0];
      bgca_pkg::CFG_HOOD_MODE:   hood_reg = val[1:0];
      bgca_pkg::CFG_SURVIVE_MIN: survive_reg = val[4:0];
      default:                   birth_reg = val[4:0];
    endcase
  endtask

  task automatic push_cmd(logic [1:0] op, int r, int c, int unsigned s);
    cmd_t t;
    t.op = op;
    t.row = r[5:0];
    t.col = c[5:0];
    t.sample = s[15:0];
    if (op == bgca_pkg::OP_LOAD && r < clamp_dim(grid_h_reg) && c < clamp_dim(grid_w_reg))
      loaded_map[r * bgca_pkg::MaxWidthDef + c] = 1'b1;
    cmd_queue.push_back(t);
  endtask

  function automatic int unsigned pick_sample();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 16'hFFFF;
      2: return thresh_reg;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // A run must only see loaded cells, so any gap in the grid in use is loaded first.
  task automatic fill_then_run();
    for (int r = 0; r < clamp_dim(grid_h_reg); r++)
      for (int c = 0; c < clamp_dim(grid_w_reg); c++)
        if (!loaded_map[r * bgca_pkg::MaxWidthDef + c])
          push_cmd(bgca_pkg::OP_LOAD, r, c, pick_sample());
    push_cmd(bgca_pkg::OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom());
  endtask

  task automatic random_phase(int n);
    int w, h, r, c, k;
    w = clamp_dim(grid_w_reg);
    h = clamp_dim(grid_h_reg);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 199);
      r = $urandom_range(0, h - 1);
      c = $urandom_range(0, w - 1);
      if (k < 5) begin
        fill_then_run();
      end else if (k < 15) begin
        push_cmd(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), $urandom());
      end else if (k < 30) begin
        // Either coordinate may land outside the grid in use.
        push_cmd($urandom_range(0, 1) ? bgca_pkg::OP_LOAD : bgca_pkg::OP_READ,
                 $urandom_range(0, 63), $urandom_range(0, 63), pick_sample());
        if (cmd_queue[$].op == bgca_pkg::OP_READ && cmd_queue[$].row < h &&
            cmd_queue[$].col < w &&
            !loaded_map[cmd_queue[$].row * bgca_pkg::MaxWidthDef + cmd_queue[$].col])
          cmd_queue[$].op = bgca_pkg::OP_LOAD;
        if (cmd_queue[$].op == bgca_pkg::OP_LOAD && cmd_queue[$].row < h &&
            cmd_queue[$].col < w)
          loaded_map[cmd_queue[$].row * bgca_pkg::MaxWidthDef + cmd_queue[$].col] = 1'b1;
      end else if (k < 110 && loaded_map[r * bgca_pkg::MaxWidthDef + c]) begin
        push_cmd(bgca_pkg::OP_READ, r, c, $urandom());
      end else begin
        push_cmd(bgca_pkg::OP_LOAD, r, c, pick_sample());
      end
    end
  endtask

  // Blocks until every queued command is accepted and every answer has come back,
  // then lets the block settle since loads leave nothing to wait for.
  task automatic wait_idle();
    while (cmd_queue.size() > 0 || in_valid || answer_queue.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_all(int w, int h, int th, int g, int m, int sv, int bn);
    write_reg(bgca_pkg::CFG_GRID_WIDTH, w);
    write_reg(bgca_pkg::CFG_GRID_HEIGHT, h);
    write_reg(bgca_pkg::CFG_THRESHOLD, th);
    write_reg(bgca_pkg::CFG_GEN_COUNT, g);
    write_reg(bgca_pkg::CFG_HOOD_MODE, m);
    write_reg(bgca_pkg::CFG_SURVIVE_MIN, sv);
    write_reg(bgca_pkg::CFG_BIRTH_MIN, bn);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed part on a 5x4 grid: sample extremes, the sample equal to the
    // threshold, out-of-grid load and read, the unused opcode, run and reads.
    set_all(5, 4, 0, 1, bgca_pkg::HOOD_DIAMOND4, 1, 2);
    push_cmd(bgca_pkg::OP_LOAD, 0, 0, 0);
    push_cmd(bgca_pkg::OP_LOAD, 0, 1, 16'hFFFF);
    push_cmd(bgca_pkg::OP_LOAD, 3, 4, 1);
    push_cmd(bgca_pkg::OP_LOAD, 4, 0, 16'hFFFF);
    push_cmd(bgca_pkg::OP_LOAD, 63, 63, 16'hFFFF);
    push_cmd(bgca_pkg::OP_READ, 0, 0, 0);
    push_cmd(bgca_pkg::OP_READ, 0, 1, 16'hFFFF);
    push_cmd(bgca_pkg::OP_READ, 3, 4, 0);
    push_cmd(bgca_pkg::OP_READ, 63, 63, 0);
    push_cmd(bgca_pkg::OP_READ, 0, 5, 0);
    push_cmd(OP_UNUSED, 63, 63, 16'hFFFF);
    fill_then_run();
    push_cmd(bgca_pkg::OP_READ, 0, 0, 0);
    push_cmd(bgca_pkg::OP_READ, 3, 4, 0);
    push_cmd(bgca_pkg::OP_READ, 1, 2, 0);
    wait_idle();

    set_all(8, 8, 32768, 2, bgca_pkg::HOOD_SQUARE8, 4, 5);
    random_phase(200);
    wait_idle();
    // Sizes of zero clamp to 1; a threshold of 65535 is never exceeded.
    set_all(0, 0, 65535, 255, bgca_pkg::HOOD_SQUARE24, 0, 0);
    random_phase(120);
    wait_idle();
    set_all(127, 2, 1000, 1, bgca_pkg::HOOD_DIAMOND12, 3, 25);
    random_phase(200);
    wait_idle();
    set_all(3, 64, 50000, 1, bgca_pkg::HOOD_SQUARE24, 12, 13);
    random_phase(200);
    wait_idle();
    set_all(6, 6, 20000, 3, bgca_pkg::HOOD_DIAMOND12, 25, 6);
    random_phase(200);
    wait_idle();
    // No generations, and survival and birth levels no neighborhood can reach.
    set_all(7, 5, 40000, 0, bgca_pkg::HOOD_SQUARE8, 31, 31);
    random_phase(200);
    wait_idle();
    set_all(10, 10, 30000, 1, bgca_pkg::HOOD_SQUARE24, 13, 14);
    random_phase(200);
    wait_idle();
    set_all(6, 9, 12345, 2, bgca_pkg::HOOD_DIAMOND4, 2, 3);
    random_phase(200);
    wait_idle();
    calm = 1'b1;
    set_all(16, 4, 45000, 2, bgca_pkg::HOOD_SQUARE8, 3, 4);
    random_phase(200);
    wait_idle();
    repeat (50) @(posedge clk);

    if (mismatches == 0 && answer_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
